@@ src/inverter_pulse_mode_selector_macros.svh @@
// Assertion helpers shared by the pulse mode selector modules.
// Every macro samples on the rising edge of clk_i and is quiet while rst_ni is low.
`ifndef INVERTER_PULSE_MODE_SELECTOR_MACROS_SVH
`define INVERTER_PULSE_MODE_SELECTOR_MACROS_SVH

// A condition that must hold on every clock edge.
`define IPMS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// A consequence that must hold on the same edge as its cause.
`define IPMS_ASSERT_IMPL(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error(msg);

// A consequence that must hold on the edge after its cause.
`define IPMS_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

@@ src/ipms_pkg.sv @@
`default_nettype none

package ipms_pkg;

  // Field widths of the words on either side.
  localparam int unsigned FreqW    = 15;
  localparam int unsigned AmpW     = 15;
  localparam int unsigned CarrierW = 9;

  // Depth of the queue between the classifier and the amplitude datapath.
  localparam int unsigned IPMS_QUEUE_DEPTH = 2;

  // Pulse modes as they appear on the output.
  typedef enum logic [3:0] {
    MODE_ONE_PULSE   = 4'd0,
    MODE_THREE_PULSE = 4'd1,
    MODE_WCHM3       = 4'd2,
    MODE_WCHM5       = 4'd3,
    MODE_WCHM7       = 4'd4,
    MODE_CHM7        = 4'd5,
    MODE_CHM9        = 4'd6,
    MODE_CHM11       = 4'd7,
    MODE_CHM13       = 4'd8,
    MODE_CHM15       = 4'd9,
    MODE_ASYNC_THI   = 4'd10,
    MODE_ASYNC       = 4'd11
  } mode_e;

  // Rows of the linear amplitude table.
  typedef enum logic [2:0] {
    ROW_HIGH  = 3'd0,  // top slope, positive offset
    ROW_P_LIN = 3'd1,  // powering, CHM and async region
    ROW_P_CHM = 3'd2,  // powering, wide CHM region
    ROW_B_CHM = 3'd3,  // braking, wide CHM region
    ROW_B_LIN = 3'd4   // braking, upper CHM 7 band
  } row_e;

  // Slopes scaled by 2^34 / 100 and offsets scaled by 2^34.
  localparam logic [21:0]        K_R0C0 = 22'd3320774;
  localparam logic [21:0]        K_R0C1 = 22'd3825205;
  localparam logic [21:0]        K_R1C0 = 22'd2536432;
  localparam logic [21:0]        K_R1C1 = 22'd3172091;
  localparam logic [21:0]        K_R1C2 = 22'd2320124;
  localparam logic signed [31:0] B_POS  = 32'sd1717986918;
  localparam logic signed [31:0] B_R0C1 = -32'sd1282853044;
  localparam logic signed [31:0] B_R1C1 = -32'sd1634939431;

  // Amplitude limits in Q1.14.
  localparam logic [AmpW-1:0] AMP_MAX       = 15'd20480;
  localparam logic [AmpW-1:0] AMP_COAST_MIN = 15'd8160;
  localparam logic [AmpW-1:0] AMP_THREE_MAX = 15'd16384;

  // Carrier used for braking in the async region.
  localparam logic [CarrierW-1:0] CARRIER_BRAKE = 9'd400;

  // Stepped carrier table for powering below 24 Hz, thresholds descending.
  localparam int unsigned CarrierSteps = 8;
  localparam logic [FreqW-1:0] CARRIER_STEP [CarrierSteps] = '{
    15'd560, 15'd500, 15'd430, 15'd340, 15'd270, 15'd200, 15'd150, 15'd50
  };
  localparam logic [CarrierW-1:0] CARRIER_VAL [CarrierSteps+1] = '{
    9'd400, 9'd350, 9'd311, 9'd294, 9'd262, 9'd233, 9'd223, 9'd196, 9'd175
  };

  // One classified word waiting for the amplitude datapath.
  typedef struct packed {
    mode_e               mode;
    row_e                row;
    logic [CarrierW-1:0] carrier;
    logic                coast;
    logic                zero_amp;
    logic [FreqW-1:0]    freq;
  } item_t;

  function automatic logic [21:0] row_k(input row_e row);
    logic [21:0] k;
    case (row)
      ROW_P_LIN: k = K_R0C0;
      ROW_P_CHM: k = K_R0C1;
      ROW_B_CHM: k = K_R1C1;
      ROW_B_LIN: k = K_R1C0;
      default:   k = K_R1C2;
    endcase
    return k;
  endfunction

  function automatic logic signed [31:0] row_b(input row_e row);
    logic signed [31:0] b;
    case (row)
      ROW_P_CHM: b = B_R0C1;
      ROW_B_CHM: b = B_R1C1;
      default:   b = B_POS;
    endcase
    return b;
  endfunction

endpackage

`default_nettype wire

@@ src/ipms_front.sv @@
`default_nettype none

module ipms_front (
  input  wire logic                        s_valid_i,
  output logic                             s_ready_o,
  input  wire logic [ipms_pkg::FreqW-1:0]  cmd_freq_i,
  input  wire logic [ipms_pkg::FreqW-1:0]  sin_freq_i,
  input  wire logic                        brake_i,
  input  wire logic                        coast_i,
  output logic                             push_valid_o,
  input  wire logic                        push_ready_i,
  output ipms_pkg::item_t                  push_item_o
);
  import ipms_pkg::*;

  logic [FreqW-1:0] cf;
  logic [FreqW-1:0] sf;
  logic [FreqW-1:0] carrier_freq;
  logic [3:0]       carrier_idx;
  item_t            item;

  assign cf = cmd_freq_i;
  assign sf = sin_freq_i;

  // The word is taken as soon as the queue has room.
  assign push_valid_o = s_valid_i;
  assign s_ready_o    = push_ready_i;
  assign push_item_o  = item;

  // In free run the sine frequency may also step the carrier up, so the
  // larger of the two frequencies drives the table.
  assign carrier_freq = (coast_i && (sf > cf)) ? sf : cf;

  // First step from the top that the frequency reaches; past the end is
  // the lowest carrier.
  always_comb begin
    carrier_idx = 4'(CarrierSteps);
    for (int i = CarrierSteps - 1; i >= 0; i--) begin
      if (carrier_freq >= CARRIER_STEP[i]) begin
        carrier_idx = 4'(i);
      end
    end
  end

  // Priority chains for powering and braking.
  always_comb begin
    item.mode     = MODE_ONE_PULSE;
    item.row      = ROW_HIGH;
    item.carrier  = '0;
    item.coast    = coast_i;
    item.zero_amp = (cf == '0);
    item.freq     = cf;
    if (!brake_i) begin
      if (cf >= 15'd8000) begin
        item.mode = MODE_ONE_PULSE;
      end else if (cf >= 15'd5900) begin
        item.mode = MODE_WCHM3;
        item.row  = ROW_P_CHM;
      end else if (coast_i && (sf >= 15'd5700)) begin
        item.mode = MODE_THREE_PULSE;
      end else if (cf >= 15'd5700) begin
        item.mode = MODE_WCHM5;
        item.row  = ROW_P_CHM;
      end else if (cf >= 15'd5350) begin
        item.mode = MODE_WCHM7;
        item.row  = ROW_P_CHM;
      end else begin
        item.row = ROW_P_LIN;
        if (cf >= 15'd4350) begin
          item.mode = MODE_CHM7;
        end else if (cf >= 15'd3670) begin
          item.mode = MODE_CHM9;
        end else if (cf >= 15'd3000) begin
          item.mode = MODE_CHM11;
        end else if (cf >= 15'd2700) begin
          item.mode = MODE_CHM13;
        end else if (cf >= 15'd2400) begin
          item.mode = MODE_CHM15;
        end else begin
          item.mode    = MODE_ASYNC_THI;
          item.carrier = CARRIER_VAL[carrier_idx];
        end
      end
    end else begin
      if (cf >= 15'd7950) begin
        item.mode = MODE_ONE_PULSE;
      end else if (cf >= 15'd7070) begin
        item.mode = MODE_WCHM3;
        item.row  = ROW_B_CHM;
      end else if (coast_i && (sf >= 15'd6335)) begin
        item.mode = MODE_THREE_PULSE;
      end else if (cf >= 15'd6335) begin
        item.mode = MODE_WCHM5;
        item.row  = ROW_B_CHM;
      end else if (cf >= 15'd5684) begin
        item.mode = MODE_WCHM7;
        item.row  = ROW_B_CHM;
      end else if (cf >= 15'd5350) begin
        item.mode = MODE_CHM7;
        item.row  = ROW_B_LIN;
      end else if (cf >= 15'd4100) begin
        item.mode = MODE_CHM7;
      end else if (cf >= 15'd3450) begin
        item.mode = MODE_CHM9;
      end else if (cf >= 15'd2890) begin
        item.mode = MODE_CHM11;
      end else if (cf >= 15'd2490) begin
        item.mode = MODE_CHM13;
      end else if (cf >= 15'd2240) begin
        item.mode = MODE_CHM15;
      end else if (cf > 15'd400) begin
        item.mode    = MODE_ASYNC_THI;
        item.carrier = CARRIER_BRAKE;
      end else begin
        // Low-speed braking: plain async with the output held at zero.
        item.mode     = MODE_ASYNC;
        item.carrier  = CARRIER_BRAKE;
        item.zero_amp = 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

@@ src/ipms_queue.sv @@
`default_nettype none

`include "inverter_pulse_mode_selector_macros.svh"

module ipms_queue #(
  parameter int unsigned Depth = ipms_pkg::IPMS_QUEUE_DEPTH
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_valid_i,
  output logic                  push_ready_o,
  input  wire ipms_pkg::item_t  push_item_i,
  output logic                  pop_valid_o,
  input  wire logic             pop_ready_i,
  output ipms_pkg::item_t       pop_item_o
);
  import ipms_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  item_t            mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  count_q, count_d;
  logic             push;
  logic             pop;

  assign push_ready_o = (count_q != CntW'(Depth));
  assign pop_valid_o  = (count_q != '0);
  assign pop_item_o   = mem_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  // Pointer and fill level updates, wrapping at the depth.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Storage needs no reset; the fill level guards every read.
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

  // The fill level follows pushes and pops one for one.
  `IPMS_ASSERT_NEXT(a_count_up, push && !pop, count_q == $past(count_q) + 1'b1,
    "queue level did not rise on a push")
  `IPMS_ASSERT_NEXT(a_count_down, pop && !push, count_q == $past(count_q) - 1'b1,
    "queue level did not fall on a pop")

endmodule

`default_nettype wire

@@ src/ipms_back.sv @@
`default_nettype none

`include "inverter_pulse_mode_selector_macros.svh"

module ipms_back (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            in_valid_i,
  output logic                                 in_ready_o,
  input  wire ipms_pkg::item_t                 in_item_i,
  output logic                                 out_valid_o,
  input  wire logic                            out_ready_i,
  output ipms_pkg::mode_e                      pwm_mode_o,
  output logic [ipms_pkg::AmpW-1:0]            amplitude_o,
  output logic [ipms_pkg::CarrierW-1:0]        carrier_hz_o
);
  import ipms_pkg::*;

  logic                       advance;
  logic [21:0]                k;
  logic signed [31:0]         b;
  logic [36:0]                prod;
  logic signed [38:0]         sum_d;

  logic                       s1_valid_q;
  logic signed [38:0]         s1_sum_q;
  mode_e                      s1_mode_q;
  logic [CarrierW-1:0]        s1_carrier_q;
  logic                       s1_coast_q;
  logic                       s1_zero_q;

  logic [37:0]                rounded;
  logic [17:0]                amp_raw;
  logic [AmpW+1:0]            amp_x4;
  logic [33:0]                amp_div;
  logic [AmpW-1:0]            amp_d;

  logic                       out_valid_q;
  mode_e                      out_mode_q;
  logic [AmpW-1:0]            out_amp_q;
  logic [CarrierW-1:0]        out_carrier_q;

  // Rounded line value clamped to AMP_MAX in Q1.14, zero when negative.
  function automatic logic [AmpW-1:0] amp_d_pre(input logic neg, input logic [17:0] a);
    logic [AmpW-1:0] r;
    if (neg) begin
      r = '0;
    end else if (a > 18'(AMP_MAX)) begin
      r = AMP_MAX;
    end else begin
      r = a[AmpW-1:0];
    end
    return r;
  endfunction

  // The whole pipeline moves whenever the output register can take a word.
  assign advance    = !out_valid_q || out_ready_i;
  assign in_ready_o = advance;

  // Stage one: amplitude line k*f + B with 34 fractional bits.
  assign k     = row_k(in_item_i.row);
  assign b     = row_b(in_item_i.row);
  assign prod  = 37'(k) * 37'(in_item_i.freq);
  assign sum_d = $signed({2'b00, prod}) + {{7{b[31]}}, b};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (advance) begin
      s1_valid_q  <= in_valid_i;
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      s1_sum_q      <= sum_d;
      s1_mode_q     <= in_item_i.mode;
      s1_carrier_q  <= in_item_i.carrier;
      s1_coast_q    <= in_item_i.coast;
      s1_zero_q     <= in_item_i.zero_amp;
    end
  end

  // Stage two: round to Q1.14, clamp, apply the cuts and the three-pulse
  // scaling. The divide by five is a multiply by ceil(2^18/5), exact for
  // every value below 2^18.
  assign rounded = s1_sum_q[37:0] + 38'(20'h80000);
  assign amp_raw = rounded[37:20];
  assign amp_x4  = {amp_d_pre(s1_sum_q[38], amp_raw), 2'b00};
  assign amp_div = 34'(amp_x4) * 34'd52429;

  always_comb begin
    amp_d = amp_d_pre(s1_sum_q[38], amp_raw);
    if (s1_coast_q && (amp_d < AMP_COAST_MIN)) begin
      amp_d = '0;
    end
    if (s1_zero_q) begin
      amp_d = '0;
    end
    if (s1_mode_q == MODE_THREE_PULSE) begin
      amp_d = amp_div[AmpW+17:18];
    end
    if ((s1_mode_q == MODE_THREE_PULSE) && (s1_zero_q ||
        (s1_coast_q && (amp_d_pre(s1_sum_q[38], amp_raw) < AMP_COAST_MIN)))) begin
      amp_d = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_mode_q    <= s1_mode_q;
      out_amp_q     <= amp_d;
      out_carrier_q <= s1_carrier_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign pwm_mode_o   = out_mode_q;
  assign amplitude_o  = out_amp_q;
  assign carrier_hz_o = out_carrier_q;

  // Three-pulse words are scaled down, low-speed braking is silent, and
  // only async modes carry a carrier.
  `IPMS_ASSERT_IMPL(a_three_scaled, out_valid_q && (out_mode_q == MODE_THREE_PULSE),
    out_amp_q <= AMP_THREE_MAX, "three-pulse amplitude above 1.0")
  `IPMS_ASSERT_IMPL(a_async_silent, out_valid_q && (out_mode_q == MODE_ASYNC),
    (out_amp_q == '0) && (out_carrier_q == CARRIER_BRAKE),
    "low-speed braking word not silent")
  `IPMS_ASSERT_IMPL(a_carrier_async, out_valid_q && (out_carrier_q != '0),
    (out_mode_q == MODE_ASYNC) || (out_mode_q == MODE_ASYNC_THI),
    "carrier given in a synchronous mode")

endmodule

`default_nettype wire

@@ src/inverter_pulse_mode_selector.sv @@
// Pulse mode selector for a traction inverter. Each input word carries the
// commanded and the present sine frequency (0.01 Hz units) with the brake and
// free-run flags; each output word gives the PWM pulse mode, the modulation
// amplitude in unsigned Q1.14 and the async carrier in Hz (0 when synchronous).
// One word is accepted and one result given per clock cycle when the output
// side keeps up. An accepted word passes the classifier, a two-entry queue and
// a two-stage amplitude datapath (one multiply-add stage, one rounding and
// scaling stage into the output register) on its way to the output. At full
// rate the queue holds one word with one entry to spare, so the input side
// keeps taking one more word after the output side stops. There is no
// configuration and no start-up sweep; words are taken as soon as reset is
// released.
`default_nettype none

module inverter_pulse_mode_selector #(
  parameter int unsigned QueueDepth = ipms_pkg::IPMS_QUEUE_DEPTH
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // [14:0] cmd_freq, [29:15] sin_freq, [31:30] zero
  input  wire logic [31:0] s_axis_tdata,
  // [0] brake, [1] coast
  input  wire logic [1:0]  s_axis_tuser,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // [14:0] amplitude, [23:15] carrier_hz
  output logic [23:0]      m_axis_tdata,
  // [3:0] pwm_mode
  output logic [3:0]       m_axis_tuser
);
  import ipms_pkg::*;

  logic                push_valid;
  logic                push_ready;
  item_t               push_item;
  logic                pop_valid;
  logic                pop_ready;
  item_t               pop_item;
  mode_e               pwm_mode;
  logic [AmpW-1:0]     amplitude;
  logic [CarrierW-1:0] carrier_hz;

  // Classify each word into mode, table row and carrier.
  ipms_front u_front (
    .s_valid_i      (s_axis_tvalid),
    .s_ready_o      (s_axis_tready),
    .cmd_freq_i     (s_axis_tdata[14:0]),
    .sin_freq_i     (s_axis_tdata[29:15]),
    .brake_i        (s_axis_tuser[0]),
    .coast_i        (s_axis_tuser[1]),
    .push_valid_o   (push_valid),
    .push_ready_i   (push_ready),
    .push_item_o    (push_item)
  );

  // Short queue that decouples classification from the datapath.
  ipms_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_item_i  (push_item),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_item_o   (pop_item)
  );

  // Amplitude evaluation and output register.
  ipms_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (pop_valid),
    .in_ready_o   (pop_ready),
    .in_item_i    (pop_item),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .pwm_mode_o   (pwm_mode),
    .amplitude_o  (amplitude),
    .carrier_hz_o (carrier_hz)
  );

  assign m_axis_tdata = {carrier_hz, amplitude};
  assign m_axis_tuser = pwm_mode;

endmodule

`default_nettype wire
